// File: rtl/assert_macros.svh
// assertion macros shared by the brake coil sequencer rtl
// no dependencies; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/bcps_pkg.sv
// types and constants for the brake coil pwm sequencer
// used by bcps_ctrl, bcps_dpath and the top level
package bcps_pkg;

   localparam int PEAK_VOLTS = 24;
   localparam int HOLD_VOLTS = 8;

   localparam logic [15:0] START_COUNT = 16'd10;
   localparam logic [16:0] RAMP_STEP   = 17'd100;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [6:0]  HOLD_CAP    = 7'd127;

   // sequence phase codes
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_RAMP  = 2'd1;
   localparam logic [1:0] PH_PEAK  = 2'd2;
   localparam logic [1:0] PH_HOLD  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       commit;
      logic       use_hold;
      logic [1:0] phase;
   } cmd_type;

   typedef struct packed {
      logic releasing;
      logic ramp_over;
      logic hold_over;
      logic out_free;
   } status_type;

endpackage

// File: rtl/bcps_dpath.sv
// datapath: transaction capture, restoring divider, duty and hold counters,
// result register; depends on bcps_pkg and assert_macros.svh
`include "assert_macros.svh"

module bcps_dpath import bcps_pkg::*; #(
   parameter int PWM_PERIOD = 6250,
   parameter int HOLD_TICKS = 100,
   parameter int NUM_W      = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_releasing,
   input  logic [11:0] req_bus_volts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_compare_value
);

   localparam int NUM_PEAK = PEAK_VOLTS * PWM_PERIOD;
   localparam int NUM_HOLD = HOLD_VOLTS * PWM_PERIOD;

   logic             releasing_ff;
   logic [11:0]      volts_ff;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [11:0]      rem_ff, rem_in;
   logic [15:0]      duty_ff, duty_in;
   logic [6:0]       hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;

   logic [12:0] rem_shift;
   logic        ge;
   logic [31:0] quo_ext;
   logic [15:0] target;
   logic [16:0] ramp_sum;
   logic [7:0]  hold_next;
   logic        out_free;

   // one quotient bit per step
   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      ge        = rem_shift >= {1'b0, volts_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      num_in    = num_ff;
      if (cmd.load) begin
         rem_in = '0;
         num_in = cmd.use_hold ? NUM_W'(NUM_HOLD) : NUM_W'(NUM_PEAK);
      end else if (cmd.div_step) begin
         rem_in = ge ? 12'(rem_shift - {1'b0, volts_ff}) : rem_shift[11:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         num_in = {num_ff[NUM_W-2:0], 1'b0};
      end
   end

   // a zero divisor gives an all-ones quotient, which saturates as well
   assign quo_ext   = 32'(quo_ff);
   assign target    = (quo_ext > 32'(COUNT_MAX)) ? COUNT_MAX : quo_ext[15:0];
   assign ramp_sum  = {1'b0, duty_ff} + RAMP_STEP;
   assign hold_next = {1'b0, hold_ff} + 8'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.releasing = releasing_ff;
      status.ramp_over = ramp_sum > {1'b0, target};
      status.hold_over = hold_next > 8'(HOLD_TICKS);
      status.out_free  = out_free;
   end

   always_comb begin
      duty_in = duty_ff;
      hold_in = hold_ff;
      if (cmd.commit) begin
         if (releasing_ff) begin
            duty_in = '0;
         end else begin
            case (cmd.phase)
               PH_START: duty_in = START_COUNT;
               PH_RAMP: begin
                  if (status.ramp_over) begin
                     duty_in = target;
                     hold_in = '0;
                  end else begin
                     duty_in = ramp_sum[15:0];
                  end
               end
               PH_PEAK: begin
                  duty_in = target;
                  hold_in = hold_next[7] ? HOLD_CAP : hold_next[6:0];
               end
               default: duty_in = target;
            endcase
         end
      end
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff      <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         duty_ff      <= duty_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         releasing_ff <= req_releasing;
         volts_ff     <= req_bus_volts;
      end
      if (cmd.commit) begin
         rsp_data_ff <= duty_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_data_ff;

   `ASSERT_IMPLIES(a_commit_slot_free, clock, reset, cmd.commit, out_free)
   `ASSERT_NEXT(a_start_count, clock, reset,
      cmd.commit && !releasing_ff && cmd.phase == PH_START, duty_ff == START_COUNT)

endmodule

// File: rtl/bcps_ctrl.sv
// controller: transaction sequencing, divider step count, sequence phase
// depends on bcps_pkg and assert_macros.svh
`include "assert_macros.svh"

module bcps_ctrl import bcps_pkg::*; #(
   parameter int NUM_W = 18
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int STEP_W = $clog2(NUM_W);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        phase_ff, phase_in;
   logic              last_step;

   assign last_step = step_ff == STEP_W'(NUM_W - 1);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.commit   = 1'b0;
      cmd.use_hold = phase_ff == PH_HOLD;
      cmd.phase    = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
               if (status.releasing) begin
                  phase_in = PH_START;
               end else begin
                  case (phase_ff)
                     PH_START: phase_in = PH_RAMP;
                     PH_RAMP:  phase_in = status.ramp_over ? PH_PEAK : PH_RAMP;
                     PH_PEAK:  phase_in = status.hold_over ? PH_HOLD : PH_PEAK;
                     default:  phase_in = PH_HOLD;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         phase_ff <= PH_START;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   `ASSERT_NEXT(a_div_to_write, clock, reset,
      state_ff == ST_DIV && last_step, state_ff == ST_WRITE)
   `ASSERT_NEXT(a_release_restarts, clock, reset,
      cmd.commit && status.releasing, phase_ff == PH_START)

endmodule

// File: rtl/brake_coil_pwm_sequencer.sv
// brake coil pwm sequencer, peak and hold, top level
// depends on bcps_pkg, bcps_ctrl and bcps_dpath
//
// One request transaction per control tick carries req_releasing and
// req_bus_volts; each gives exactly one response transaction with
// rsp_compare_value. A transaction moves when valid is high and stall is low.
// The peak (24 V) and hold (8 V) counts are 24*PWM_PERIOD/V and
// 8*PWM_PERIOD/V, worked out by a restoring divider that yields one
// quotient bit a cycle over NUM_W = clog2(24*PWM_PERIOD+1) bits, 18 at the
// default period. A request passes through capture, NUM_W divider steps
// and the update before its response is registered, and the block takes
// no new request until that update is done.
// req_stall is high while a transaction is in progress. A finished
// response waits in the output register while the next request is taken;
// if that register is still stalled when the next update is due, the
// update waits and req_stall stays high. Synchronous reset returns the
// sequence to its start phase with compare and hold counts at zero and
// drops rsp_valid.
module brake_coil_pwm_sequencer import bcps_pkg::*; #(
   parameter int PWM_PERIOD = 6250,
   parameter int HOLD_TICKS = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_releasing,
   input  logic [11:0] req_bus_volts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_compare_value
);

   localparam int NUM_W = $clog2(PEAK_VOLTS * PWM_PERIOD + 1);

   cmd_type    cmd;
   status_type status;

   bcps_ctrl #(
      .NUM_W (NUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bcps_dpath #(
      .PWM_PERIOD (PWM_PERIOD),
      .HOLD_TICKS (HOLD_TICKS),
      .NUM_W      (NUM_W)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_releasing     (req_releasing),
      .req_bus_volts     (req_bus_volts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value)
   );

endmodule

// File: sim/brake_coil_pwm_sequencer_tb.sv
// testbench for the brake coil pwm sequencer (peak and hold)
// needs bcps_pkg and brake_coil_pwm_sequencer; a scoreboard class predicts each compare value
// and checks responses in order while random idling and stalls run on both channels
`timescale 1ns / 100ps

module brake_coil_pwm_sequencer_tb;
   import bcps_pkg::*;

   localparam int COIL_PERIOD  = 6250;
   localparam int HOLD_LIMIT   = 100;
   localparam int IDLE_PCT     = 19;
   localparam int ITEM_TARGET  = 2000;
   localparam int QUIET_FROM   = 1000;
   localparam int QUIET_TO     = 1400;
   localparam int SETTLE_TICKS = 40;
   localparam int DEAD_LIMIT   = 2000;

   class coil_scoreboard;
      logic [1:0]  phase;
      logic [15:0] duty;
      logic [6:0]  hold_cnt;
      logic [15:0] compare_q[$];
      int          mismatches;

      function new();
         phase      = PH_START;
         duty       = '0;
         hold_cnt   = '0;
         mismatches = 0;
      endfunction

      // truncated quotient, saturating at zero volts and above the 16 bit range
      function logic [15:0] target_for(int unsigned volt_factor, logic [11:0] volts);
         int unsigned quotient;
         if (volts == '0)
            return COUNT_MAX;
         quotient = (volt_factor * COIL_PERIOD) / volts;
         return (quotient > COUNT_MAX) ? COUNT_MAX : quotient[15:0];
      endfunction

      function void note_tick(logic rel, logic [11:0] volts);
         logic [15:0] peak;
         logic [15:0] hold_level;
         logic [16:0] ramp_sum;
         logic [7:0]  hold_next;
         if (rel) begin
            duty  = '0;
            phase = PH_START;
         end else begin
            peak       = target_for(PEAK_VOLTS, volts);
            hold_level = target_for(HOLD_VOLTS, volts);
            case (phase)
               PH_START: begin
                  duty  = START_COUNT;
                  phase = PH_RAMP;
               end
               PH_RAMP: begin
                  // formed one bit wider so the ramp never wraps
                  ramp_sum = {1'b0, duty} + RAMP_STEP;
                  if (ramp_sum > {1'b0, peak}) begin
                     ramp_sum = {1'b0, peak};
                     hold_cnt = '0;
                     phase    = PH_PEAK;
                  end
                  duty = ramp_sum[15:0];
               end
               PH_PEAK: begin
                  duty      = peak;
                  hold_next = {1'b0, hold_cnt} + 8'd1;
                  if (hold_next > HOLD_LIMIT)
                     phase = PH_HOLD;
                  hold_cnt = (hold_next > {1'b0, HOLD_CAP}) ? HOLD_CAP : hold_next[6:0];
               end
               default: begin
                  duty = hold_level;
               end
            endcase
         end
         compare_q.push_back(duty);
      endfunction

      task report_mismatch(string what, logic [15:0] got, logic [15:0] wanted);
         $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, wanted);
         mismatches++;
      endtask

      task check_value(logic [15:0] got);
         logic [15:0] wanted;
         if (compare_q.size() == 0) begin
            report_mismatch("response with nothing outstanding", got, '0);
         end else begin
            wanted = compare_q.pop_front();
            if (got !== wanted)
               report_mismatch("compare_value", got, wanted);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_releasing = 1'b0;
   logic [11:0] req_bus_volts = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_compare_value;

   bit             idle_on = 1'b1;
   int             items_sent = 0;
   coil_scoreboard sb = new();

   brake_coil_pwm_sequencer #(
      .PWM_PERIOD(COIL_PERIOD),
      .HOLD_TICKS(HOLD_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_releasing(req_releasing),
      .req_bus_volts(req_bus_volts),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_compare_value(rsp_compare_value)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_tick(input logic rel, input logic [11:0] volts);
      idle_on = !(items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid     = 1'b0;
         req_releasing = 1'($urandom_range(1));
         req_bus_volts = 12'($urandom_range(4095));
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_releasing = rel;
      req_bus_volts = volts;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_tick(rel, volts);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_all_returned();
      req_valid = 1'b0;
      while (sb.compare_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [11:0] pick_volts();
      case ($urandom_range(9))
         0:       return 12'($urandom_range(3));
         1, 2, 3: return 12'($urandom_range(4095));
         default: return 12'($urandom_range(60, 18));
      endcase
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         rsp_stall = idle_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_value(rsp_compare_value);
      end
   end

   // ends the run when no transaction moves on either channel for too long
   initial begin : watchdog
      int dead_cycles;
      dead_cycles = 0;
      while (dead_cycles < DEAD_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            dead_cycles = 0;
         else
            dead_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int          run_len;
      logic [11:0] base_volts;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_tick(1'b0, 12'd24);
      send_tick(1'b0, 12'd24);
      send_tick(1'b1, 12'hFFF);
      send_tick(1'b0, 12'd0);
      send_tick(1'b0, 12'd0);
      send_tick(1'b0, 12'hFFF);     // ramp overshoots a tiny peak and clamps
      send_tick(1'b0, 12'hFFF);
      send_tick(1'b0, 12'd0);       // zero volts saturates the peak
      send_tick(1'b0, 12'd1);       // quotient far beyond 16 bits
      send_tick(1'b0, 12'd2);
      send_tick(1'b0, 12'd3);
      send_tick(1'b1, 12'd0);       // release keeps the hold counter
      send_tick(1'b0, 12'hAAA);
      send_tick(1'b0, 12'h555);
      send_tick(1'b0, 12'd48);
      send_tick(1'b1, 12'h555);
      send_tick(1'b1, 12'hAAA);
      send_tick(1'b0, 12'd12);
      send_tick(1'b0, 12'd12);
      send_tick(1'b0, 12'd4000);
      wait_all_returned();

      // slow ramp to a saturated peak, runs past the top of the 16 bit range
      send_tick(1'b1, 12'($urandom_range(4095)));
      repeat (680) send_tick(1'b0, 12'($urandom_range(2)));
      wait_all_returned();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(99) < 80) begin
            base_volts = pick_volts();
            send_tick(1'b1, 12'($urandom_range(4095)));
            run_len = $urandom_range(300, 20);
            repeat (run_len)
               send_tick(1'b0, ($urandom_range(99) < 85) ? base_volts : pick_volts());
         end else begin
            run_len = $urandom_range(20, 1);
            repeat (run_len)
               send_tick(1'($urandom_range(1)), 12'($urandom_range(4095)));
         end
         if ($urandom_range(9) == 0)
            wait_all_returned();
      end

      wait_all_returned();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (sb.mismatches == 0 && sb.compare_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bcps_pkg.sv
rtl/bcps_dpath.sv
rtl/bcps_ctrl.sv
rtl/brake_coil_pwm_sequencer.sv
sim/brake_coil_pwm_sequencer_tb.sv
